FILE: rtl/ray_sphere_intersection_defines.svh
// Assertion macros used by the RTL
`ifndef RAY_SPHERE_INTERSECTION_DEFINES_SVH
`define RAY_SPHERE_INTERSECTION_DEFINES_SVH

// a implies b on the next cycle
`define RSI_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("lbl");

// a implies b in the same cycle
`define RSI_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("lbl");

`endif

FILE: rtl/rsi_pkg.sv
package rsi_pkg;
    localparam int CoordW   = 32;
    localparam int DirW     = 18;
    localparam int RadW     = 31;
    localparam int TW       = 33;
    localparam int VW       = 52;
    localparam int DiscW    = 106;
    localparam int SqrtW    = 53;
    localparam int FrontLat = 6;
    localparam int QDepth   = 8;

    localparam logic [1:0] RegCx = 2'd0;
    localparam logic [1:0] RegCy = 2'd1;
    localparam logic [1:0] RegCz = 2'd2;
    localparam logic [1:0] RegR  = 2'd3;

    // ray plus derived terms, passed front to back
    typedef struct packed {
        logic signed [CoordW-1:0] ox;
        logic signed [CoordW-1:0] oy;
        logic signed [CoordW-1:0] oz;
        logic signed [DirW-1:0]   dx;
        logic signed [DirW-1:0]   dy;
        logic signed [DirW-1:0]   dz;
        logic signed [VW-1:0]     v;
        logic signed [DiscW-1:0]  disc;
    } ray_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [CoordW-1:0] t;
        logic signed [CoordW-1:0] px;
        logic signed [CoordW-1:0] py;
        logic signed [CoordW-1:0] pz;
    } rsi_result_t;

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [VW:0] x);
        logic signed [VW:0] mx;
        logic signed [VW:0] mn;
        mx = (VW+1)'(64'sd2147483647);
        mn = -(VW+1)'(64'sd2147483648);
        if (x > mx)
            sat32 = CoordW'(mx);
        else if (x < mn)
            sat32 = CoordW'(mn);
        else
            sat32 = x[CoordW-1:0];
    endfunction
endpackage

FILE: rtl/rsi_front.sv
// Front: T = C - O, products, v and discriminant over six stages
module rsi_front
    import rsi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [CoordW-1:0] ox,
    input  logic signed [CoordW-1:0] oy,
    input  logic signed [CoordW-1:0] oz,
    input  logic signed [DirW-1:0]   dx,
    input  logic signed [DirW-1:0]   dy,
    input  logic signed [DirW-1:0]   dz,
    input  logic signed [CoordW-1:0] cx,
    input  logic signed [CoordW-1:0] cy,
    input  logic signed [CoordW-1:0] cz,
    input  logic        [RadW-1:0]   rad,
    output logic                     out_valid,
    output ray_item_t                out_item
);
    localparam int HalfW = VW / 2;

    logic [FrontLat-1:0]       vld_reg;
    logic signed [CoordW-1:0]  o_reg [FrontLat][3];
    logic signed [DirW-1:0]    d_reg [FrontLat][3];
    logic signed [TW-1:0]      t_reg [3];
    logic signed [TW+DirW-1:0] tv_reg [3];
    logic [2*TW-1:0]           tt_reg [3];
    logic [2*RadW-1:0]         rr_reg [3];
    logic signed [VW-1:0]      v_reg [4];
    logic [2*TW+1:0]           csq_reg;
    logic [VW-1:0]             vm_reg;
    logic signed [DiscW-1:0]   rc_reg [2];
    logic [2*HalfW-1:0]        hh_reg;
    logic [2*HalfW-1:0]        hl_reg;
    logic [2*HalfW-1:0]        ll_reg;
    logic signed [DiscW-1:0]   disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[FrontLat-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // ray fields ride along with the arithmetic
            o_reg[0] <= '{ox, oy, oz};
            d_reg[0] <= '{dx, dy, dz};
            for (int k = 1; k < FrontLat; k++)
            begin
                o_reg[k] <= o_reg[k-1];
                d_reg[k] <= d_reg[k-1];
            end
            // stage 0: differences, r^2
            t_reg[0]  <= TW'(cx) - TW'(ox);
            t_reg[1]  <= TW'(cy) - TW'(oy);
            t_reg[2]  <= TW'(cz) - TW'(oz);
            rr_reg[0] <= (2*RadW)'(rad) * (2*RadW)'(rad);
            // stage 1: products
            for (int i = 0; i < 3; i++)
            begin
                tv_reg[i] <= t_reg[i] * d_reg[0][i];
                tt_reg[i] <= (2*TW)'(t_reg[i] < 0 ? -t_reg[i] : t_reg[i])
                             * (2*TW)'(t_reg[i] < 0 ? -t_reg[i] : t_reg[i]);
            end
            rr_reg[1] <= rr_reg[0];
            // stage 2: sums
            v_reg[0]  <= VW'(tv_reg[0]) + VW'(tv_reg[1]) + VW'(tv_reg[2]);
            csq_reg   <= (2*TW+2)'(tt_reg[0]) + (2*TW+2)'(tt_reg[1])
                         + (2*TW+2)'(tt_reg[2]);
            rr_reg[2] <= rr_reg[1];
            // stage 3: |v| and r^2 - |T|^2
            v_reg[1]  <= v_reg[0];
            vm_reg    <= VW'(v_reg[0] < 0 ? -v_reg[0] : v_reg[0]);
            rc_reg[0] <= DiscW'({rr_reg[2], 32'd0}) - DiscW'({csq_reg, 32'd0});
            // stage 4: v^2 as three half-width partial products
            v_reg[2]  <= v_reg[1];
            rc_reg[1] <= rc_reg[0];
            hh_reg    <= (2*HalfW)'(vm_reg[VW-1:HalfW]) * (2*HalfW)'(vm_reg[VW-1:HalfW]);
            hl_reg    <= (2*HalfW)'(vm_reg[VW-1:HalfW]) * (2*HalfW)'(vm_reg[HalfW-1:0]);
            ll_reg    <= (2*HalfW)'(vm_reg[HalfW-1:0]) * (2*HalfW)'(vm_reg[HalfW-1:0]);
            // stage 5: discriminant
            v_reg[3]  <= v_reg[2];
            disc_reg  <= rc_reg[1] + (DiscW'(hh_reg) << (2*HalfW))
                         + (DiscW'(hl_reg) << (HalfW+1)) + DiscW'(ll_reg);
        end
    end

    assign out_valid = vld_reg[FrontLat-1];
    always_comb
    begin
        out_item.ox   = o_reg[FrontLat-1][0];
        out_item.oy   = o_reg[FrontLat-1][1];
        out_item.oz   = o_reg[FrontLat-1][2];
        out_item.dx   = d_reg[FrontLat-1][0];
        out_item.dy   = d_reg[FrontLat-1][1];
        out_item.dz   = d_reg[FrontLat-1][2];
        out_item.v    = v_reg[3];
        out_item.disc = disc_reg;
    end
endmodule

FILE: rtl/rsi_queue.sv
// Small FIFO between front and back
module rsi_queue
    import rsi_pkg::*;
#(
    parameter int Depth = QDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  ray_item_t wr_data,
    input  logic      rd_en,
    output ray_item_t rd_data,
    output logic      empty,
    output logic [$clog2(Depth+1)-1:0] count
);
    localparam int AW = $clog2(Depth);
    ray_item_t mem_reg [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(Depth+1)-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
endmodule

FILE: rtl/rsi_back.sv
// Back: pipelined square root (one bit per stage), then t and the point
module rsi_back
    import rsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ray_item_t   in_item,
    output logic        out_valid,
    output rsi_result_t out_res
);
    localparam int NS = SqrtW;
    localparam int NP = NS + 4;

    logic [NP-1:0]    vld_reg;
    ray_item_t        it_reg  [NS+1];
    logic [SqrtW-1:0] s_reg   [NS+1];
    logic [2*SqrtW-1:0] sq_reg [NS+1];
    logic signed [VW:0] dt_reg;
    ray_item_t        ie_reg, if_reg;
    logic signed [CoordW-1:0] tq_reg;
    logic signed [CoordW+DirW-1:0] pr_reg [3];
    rsi_result_t      res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NP-2:0], in_valid};
    end

    // square root: stage k decides bit NS-1-k; s^2 is kept incrementally
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[0] <= in_item;
            s_reg[0]  <= '0;
            sq_reg[0] <= '0;
            for (int k = 0; k < NS; k++)
            begin
                logic [2*SqrtW-1:0] cand;
                cand = sq_reg[k] + ((2*SqrtW)'(s_reg[k]) << (NS - k))
                       + ((2*SqrtW)'(1) << (2*(NS-1-k)));
                it_reg[k+1] <= it_reg[k];
                if (!it_reg[k].disc[DiscW-1]
                    && (DiscW)'(cand) <= it_reg[k].disc)
                begin
                    s_reg[k+1]  <= s_reg[k] | (SqrtW'(1) << (NS-1-k));
                    sq_reg[k+1] <= cand;
                end
                else
                begin
                    s_reg[k+1]  <= s_reg[k];
                    sq_reg[k+1] <= sq_reg[k];
                end
            end
            // t raw
            ie_reg <= it_reg[NS];
            dt_reg <= (VW+1)'(it_reg[NS].v) - (VW+1)'(s_reg[NS]);
            // saturate t
            if_reg <= ie_reg;
            tq_reg <= sat32(dt_reg >>> 16);
            // products and result
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[i] <= tq_reg * (i == 0 ? if_reg.dx : (i == 1 ? if_reg.dy : if_reg.dz));
            end
        end
    end

    // final stage registered with products in the same edge as pr_reg
    ray_item_t ig_reg;
    logic signed [CoordW-1:0] tg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ig_reg <= if_reg;
            tg_reg <= tq_reg;
        end
    end

    always_comb
    begin
        res_c.hit = !ig_reg.disc[DiscW-1];
        res_c.t   = res_c.hit ? tg_reg : '0;
        res_c.px  = res_c.hit ? sat32((VW+1)'(ig_reg.ox) + (VW+1)'(pr_reg[0] >>> 16)) : '0;
        res_c.py  = res_c.hit ? sat32((VW+1)'(ig_reg.oy) + (VW+1)'(pr_reg[1] >>> 16)) : '0;
        res_c.pz  = res_c.hit ? sat32((VW+1)'(ig_reg.oz) + (VW+1)'(pr_reg[2] >>> 16)) : '0;
    end

    assign out_valid = vld_reg[NP-1];
    assign out_res   = res_c;
endmodule

FILE: rtl/ray_sphere_intersection.sv
// Channel  | Dir | Content
// s_axis   | in  | tdata[151:0]: origin_x,y,z (32b each), dir_x,y,z (18b each)
// m_axis   | out | tdata[135:0]: hit, distance_t, point_x, point_y, point_z
// apb      | in  | center_x, center_y, center_z, sphere_radius at 0,4,8,12
// One ray accepted per cycle while s_axis_tready is high; path from s_axis to m_axis_tvalid:
// front, queue, back (53 square-root stages, t, saturation, products).
// Reset is asynchronous, active low; no clearing pass.
// The front never stalls; s_axis_tready drops when front plus queue occupancy
// reaches QueueDepth (8 covers the front depth plus one, so no gaps otherwise).
// The back pipeline stalls as a whole while m_axis holds a result.
`include "ray_sphere_intersection_defines.svh"
module ray_sphere_intersection
    import rsi_pkg::*;
#(
    parameter int QueueDepth = QDepth
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,  // ox, oy, oz, dx, dy, dz, pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // hit, t, px, py, pz, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic signed [CoordW-1:0] cx_reg, cy_reg, cz_reg;
    logic [RadW-1:0] r_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            r_reg  <= RadW'(65536);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                RegCx: cx_reg <= pwdata;
                RegCy: cy_reg <= pwdata;
                RegCz: cz_reg <= pwdata;
                RegR:  r_reg  <= pwdata[RadW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            RegCx:   prdata = cx_reg;
            RegCy:   prdata = cy_reg;
            RegCz:   prdata = cz_reg;
            RegR:    prdata = {1'b0, r_reg};
            default: prdata = '0;
        endcase
    end

    // input is accepted while the queue has room for everything in flight
    logic f_valid, q_empty, q_rd, b_valid, b_en;
    ray_item_t f_item, q_item;
    rsi_result_t b_res;
    logic [$clog2(QueueDepth+1)-1:0] q_count;
    logic [3:0] f_count;

    logic f_en;
    assign f_en = 1'b1;
    assign s_axis_tready = (32'(q_count) + 32'(f_count)) < 32'(QueueDepth);

    // rays inside the front pipeline
    logic [FrontLat-1:0] fv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else
            fv_reg <= {fv_reg[FrontLat-2:0], s_axis_tvalid & s_axis_tready};
    end
    always_comb
    begin
        f_count = 4'($countones(fv_reg));
    end

    rsi_front u_front (
        .clk(clk), .rst_n(rst_n), .en(f_en),
        .in_valid(s_axis_tvalid & s_axis_tready),
        .ox(s_axis_tdata[31:0]), .oy(s_axis_tdata[63:32]), .oz(s_axis_tdata[95:64]),
        .dx(s_axis_tdata[113:96]), .dy(s_axis_tdata[131:114]),
        .dz(s_axis_tdata[149:132]),
        .cx(cx_reg), .cy(cy_reg), .cz(cz_reg), .rad(r_reg),
        .out_valid(f_valid), .out_item(f_item)
    );

    // back pipeline advances when output is free to take
    assign b_en = m_axis_tready | ~m_axis_tvalid;
    assign q_rd = !q_empty && b_en;

    rsi_queue #(.Depth(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_item),
        .rd_en(q_rd), .rd_data(q_item), .empty(q_empty), .count(q_count)
    );

    rsi_back u_back (
        .clk(clk), .rst_n(rst_n), .en(b_en), .in_valid(q_rd), .in_item(q_item),
        .out_valid(b_valid), .out_res(b_res)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {7'd0, b_res.pz, b_res.py, b_res.px, b_res.t, b_res.hit};

    `RSI_ASSERT_NOW(a_no_qwrite_full, f_valid, 32'(q_count) < 32'(QueueDepth) || q_rd)
    `RSI_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RSI_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[135:129] == 7'd0)
endmodule
